FILE: rtl/core/itrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_pkg
// Shared types, constants and the digit-to-ASCII mapping for the integer to
// radix digits converter.
// ----------------------------------------------------------------------------
package itrd_pkg;

   localparam int RADIX_BITS = 6;
   localparam int DIGIT_BITS = 6;
   localparam int CHAR_BITS  = 7;

   localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;

   localparam logic [DIGIT_BITS-1:0] DEC_BASE   = 6'd10;
   localparam logic [CHAR_BITS-1:0]  ASCII_ZERO = 7'd48;
   localparam logic [CHAR_BITS-1:0]  ASCII_A    = 7'd65;

   // one-hot sequencer states
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   // '0'..'9' below ten, 'A'..'Z' from ten up
   function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [DIGIT_BITS-1:0] d);
      logic [DIGIT_BITS-1:0] off;
      begin
         off = d - DEC_BASE;
         if (d < DEC_BASE) begin
            digit_to_ascii = ASCII_ZERO + {1'b0, d};
         end else begin
            digit_to_ascii = ASCII_A + {1'b0, off};
         end
      end
   endfunction

endpackage

FILE: rtl/core/itrd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module itrd_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 31
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/integer_to_radix_digits.sv
`timescale 1ns / 1ps
// Digits are found by repeated restoring division, then read out of the digit RAM
//   one per cycle, MSD first; the registered RAM read puts each digit on the
//   output in the cycle after its read.
// One request at a time: start is taken only in idle; busy drops as the last digit shows.
// The receiver cannot stall: each digit is shown for exactly one cycle.
// Reset (synchronous, active high) idles the sequencer and sets radix to 10.
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// Converts one unsigned integer into ASCII digits of a configurable radix
// (2..36) by repeated division, then streams the digits out MSD first.
// ----------------------------------------------------------------------------
module integer_to_radix_digits #(
   parameter int VALUE_BITS = 31
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              start,
   output logic                              busy,
   input  logic [VALUE_BITS-1:0]             req_value,
   // digit stream
   output logic                              rsp_strobe,
   output logic [itrd_pkg::CHAR_BITS-1:0]    rsp_digit_char,
   output logic                              rsp_last_digit,
   // radix register
   input  logic                              csr_wr_en,
   input  logic [itrd_pkg::RADIX_BITS-1:0]   csr_wr_data
);

   import itrd_pkg::*;

   localparam int ADDR_BITS = $clog2(VALUE_BITS);     // digit index / bit counter
   localparam int CNT_BITS  = $clog2(VALUE_BITS + 1); // digit count, holds VALUE_BITS

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   state_type               state_ff,  state_in;
   logic [RADIX_BITS-1:0]   radix_ff;
   logic [VALUE_BITS-1:0]   quot_ff,   quot_in;    // dividend in, quotient out
   logic [DIGIT_BITS-1:0]   rem_ff,    rem_in;     // partial remainder
   logic [ADDR_BITS-1:0]    bit_ff,    bit_in;     // division step counter
   logic [CNT_BITS-1:0]     cnt_ff,    cnt_in;     // digits found so far
   logic [ADDR_BITS-1:0]    idx_ff,    idx_in;     // readout index, MSD down
   logic                    pend_ff,   pend_in;    // RAM read data is a digit
   logic                    last_ff,   last_in;

   // ------------------------------------------------------------------------
   // Shared restoring divider datapath: one quotient bit per cycle
   // ------------------------------------------------------------------------
   logic [RADIX_BITS-1:0]   eff_radix;
   logic [RADIX_BITS:0]     trial;
   logic [RADIX_BITS:0]     diff;
   logic                    qbit;
   logic [VALUE_BITS-1:0]   quot_shift;
   logic [DIGIT_BITS-1:0]   rem_next;
   logic                    div_last;

   // out-of-range radix codes clamp to the nearest legal base
   always_comb begin
      if (radix_ff < RADIX_MIN) begin
         eff_radix = RADIX_MIN;
      end else if (radix_ff > RADIX_MAX) begin
         eff_radix = RADIX_MAX;
      end else begin
         eff_radix = radix_ff;
      end
   end

   assign trial      = {rem_ff, quot_ff[VALUE_BITS-1]};
   assign qbit       = (trial >= {1'b0, eff_radix});
   assign diff       = qbit ? (trial - {1'b0, eff_radix}) : trial;
   assign rem_next   = diff[DIGIT_BITS-1:0];
   assign quot_shift = {quot_ff[VALUE_BITS-2:0], qbit};
   assign div_last   = (bit_ff == ADDR_BITS'(VALUE_BITS - 1));

   // ------------------------------------------------------------------------
   // Digit store
   // ------------------------------------------------------------------------
   logic                    ram_we;
   logic                    ram_re;
   logic [DIGIT_BITS-1:0]   ram_rd_data;

   assign ram_we = (state_ff == ST_DIV) && div_last;
   assign ram_re = (state_ff == ST_EMIT);

   itrd_ram #(
      .WIDTH (DIGIT_BITS),
      .DEPTH (VALUE_BITS)
   ) u_digit_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cnt_ff[ADDR_BITS-1:0]),
      .wr_data (rem_next),
      .rd_en   (ram_re),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      bit_in   = bit_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      pend_in  = 1'b0;
      last_in  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               quot_in  = req_value;
               rem_in   = '0;
               bit_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            quot_in = quot_shift;
            if (div_last) begin
               // remainder is the next digit; restart on the quotient
               rem_in = '0;
               bit_in = '0;
               cnt_in = cnt_ff + CNT_BITS'(1);
               if (quot_shift == '0) begin
                  idx_in   = cnt_ff[ADDR_BITS-1:0];
                  state_in = ST_EMIT;
               end
            end else begin
               rem_in = rem_next;
               bit_in = bit_ff + ADDR_BITS'(1);
            end
         end
         ST_EMIT: begin
            // one read per cycle; the digit shows the cycle after
            pend_in = 1'b1;
            last_in = (idx_ff == '0);
            idx_in  = idx_ff - ADDR_BITS'(1);
            if (idx_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         radix_ff <= RADIX_RESET;
         bit_ff   <= '0;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         bit_ff   <= bit_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
         last_ff  <= last_in;
         if (csr_wr_en) begin
            radix_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      idx_ff  <= idx_in;
   end

   // ------------------------------------------------------------------------
   // Outputs
   // ------------------------------------------------------------------------
   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = pend_ff;
   assign rsp_digit_char = digit_to_ascii(ram_rd_data);
   assign rsp_last_digit = pend_ff && last_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_digit |=> !rsp_strobe)
      else $error("digit strobe after last digit");

   a_idle_only_last: assert property (@(posedge clock) disable iff (reset)
      !busy && rsp_strobe |-> rsp_last_digit)
      else $error("non-final digit while idle");

   a_rem_below_radix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < eff_radix))
      else $error("partial remainder not below radix");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(VALUE_BITS))
      else $error("digit count overflow");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (cnt_ff != '0))
      else $error("readout with no digits stored");

endmodule
